// File: sv/g2e_pkg.sv
// ----------------------------------------------------------------------------
// g2e_pkg: shared constants and types for geodetic to ECEF conversion
// Fixed-point constants (Q60 angles and fractions), cell state types and the
// arctangent table function used by the rotation cells.
// ----------------------------------------------------------------------------
package g2e_pkg;

  localparam int unsigned ROTATION_STEPS_DEF = 32;

  localparam logic [63:0] PI_Q60       = 64'h3243F6A8885A308D;
  localparam logic [63:0] HALF_PI_Q60  = PI_Q60 >> 1;
  localparam logic [63:0] GAIN_Q60     = 64'd700114967507363240;
  localparam logic [63:0] E2_Q60       = 64'd7360548640 << 20;
  localparam logic [63:0] A_Q20        = 64'd6378137000 << 20;
  localparam logic [63:0] E7_HALF_TURN = 64'd1800000000;

  // radians per 1e-7 degree, split into integer quotient and remainder
  localparam logic [63:0] DEG_Q = PI_Q60 / E7_HALF_TURN;
  localparam logic [63:0] DEG_R = PI_Q60 % E7_HALF_TURN;

  // floor(m*DEG_R / half turn) for m <= 2^31 is (m * RECIP) >> 62 with RECIP
  // rounded up, since m * half turn stays below 2^62; quotient below 2^29
  localparam int unsigned  DIV_BITS = 29;
  localparam int unsigned  RECIP_SH = 62;
  localparam logic [127:0] RECIP_W  =
    ((128'(DEG_R) << RECIP_SH) + 128'(E7_HALF_TURN) - 128'd1) / 128'(E7_HALF_TURN);
  localparam logic [59:0]  RECIP    = RECIP_W[59:0];

  // binomial series of (1 - t)^(-1/2), Horner form
  localparam int unsigned HORNER_N  = 6;
  localparam logic [63:0] HORNER_G0 = 64'd231 << 50;
  localparam logic [63:0] HORNER_C [HORNER_N] = '{
    64'd63 << 52, 64'd35 << 53, 64'd5 << 56, 64'd3 << 57, 64'd1 << 59, 64'd1 << 60
  };

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } rot_t;

  // atan(2^-i) in Q60 by its alternating power series, evaluated at elaboration
  function automatic logic [63:0] atan_q60(input int unsigned i);
    logic signed [63:0] sum;
    logic [63:0]        term;
    int unsigned        k;
    sum = '0;
    if (i == 0) begin
      return PI_Q60 >> 2;
    end
    for (k = 0; (2 * k + 1) * i <= 60; k++) begin
      term = (64'd1 << (60 - (2 * k + 1) * i)) / 64'(2 * k + 1);
      if (k[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    return unsigned'(sum);
  endfunction

endpackage

// File: sv/g2e_div_cell.sv
// ----------------------------------------------------------------------------
// g2e_div_cell: fraction part of the degree-to-radian conversion
// floor(m * DEG_R / half turn) by reciprocal multiply: two partial products of
// the 32-bit m are registered, then summed and shifted into the output register.
// ----------------------------------------------------------------------------
module g2e_div_cell (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [31:0]                    m_i,
  output logic [g2e_pkg::DIV_BITS-1:0]   quo_o
);

  logic [63:0]                  lo_q, hi_q;
  logic [95:0]                  sum;
  logic [g2e_pkg::DIV_BITS-1:0] quo_q;

  assign sum = (96'(hi_q) << 32) + 96'(lo_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q  <= 64'(m_i) * 64'(g2e_pkg::RECIP[31:0]);
      hi_q  <= 64'(m_i) * 64'(g2e_pkg::RECIP[59:32]);
      quo_q <= sum[g2e_pkg::RECIP_SH +: g2e_pkg::DIV_BITS];
    end
  end

  assign quo_o = quo_q;

endmodule

// File: sv/g2e_cordic_cell.sv
// ----------------------------------------------------------------------------
// g2e_cordic_cell: one rotation-mode CORDIC step
// Rotates (x, y) by +-atan(2^-STEP) toward driving z to zero.
// ----------------------------------------------------------------------------
module g2e_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  g2e_pkg::rot_t st_i,
  output g2e_pkg::rot_t st_o
);

  localparam logic signed [63:0] ATAN = signed'(g2e_pkg::atan_q60(STEP));

  logic signed [63:0] dx, dy;
  g2e_pkg::rot_t      st_d, st_q;

  assign dx = signed'(st_i.y) >>> STEP;
  assign dy = signed'(st_i.x) >>> STEP;

  always_comb begin
    if (!st_i.z[63]) begin
      st_d.x = st_i.x - dx;
      st_d.y = st_i.y + dy;
      st_d.z = st_i.z - ATAN;
    end else begin
      st_d.x = st_i.x + dx;
      st_d.y = st_i.y - dy;
      st_d.z = st_i.z + ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign st_o = st_q;

endmodule

// File: sv/g2e_mul.sv
// ----------------------------------------------------------------------------
// g2e_mul: pipelined unsigned Q60 multiply, (a * b) >> 60
// Four 32x32 partial products in the first stage, summed in the second.
// ----------------------------------------------------------------------------
module g2e_mul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0]  ll_q, lh_q, hl_q, hh_q;
  logic [127:0] full;
  logic [63:0]  p_q;

  assign full = 128'(ll_q) + (128'(lh_q) << 32) + (128'(hl_q) << 32) + (128'(hh_q) << 64);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= 64'(a_i[31:0])  * 64'(b_i[31:0]);
      lh_q <= 64'(a_i[31:0])  * 64'(b_i[63:32]);
      hl_q <= 64'(a_i[63:32]) * 64'(b_i[31:0]);
      hh_q <= 64'(a_i[63:32]) * 64'(b_i[63:32]);
      p_q  <= full[123:60];
    end
  end

  assign p_o = p_q;

endmodule

// File: sv/g2e_delay.sv
// ----------------------------------------------------------------------------
// g2e_delay: enabled shift line that keeps side data aligned with the pipe
// ----------------------------------------------------------------------------
module g2e_delay #(
  parameter int unsigned W = 1,
  parameter int unsigned D = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [D];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < int'(D); i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  assign q_o = sr_q[D-1];

endmodule

// File: sv/geodetic_to_ecef_convert.sv
// ----------------------------------------------------------------------------
// geodetic_to_ecef_convert: WGS84 geodetic position to ECEF millimetres
// Fully pipelined: degree conversion, CORDIC cell chains, radius series, XYZ.
// ----------------------------------------------------------------------------
// One request per clock is taken while no result is held on the output, and
// each gives one result. In order, the pipe holds the degree-to-radian
// conversion (reciprocal multiply), one fold stage, one cell per CORDIC step,
// one sign stage, and the pipelined Q60 multipliers for the radius series and
// the X/Y/Z products.
// The whole pipe advances together; while a result is held on the output
// (m_tvalid_o high, m_tready_i low) the pipe and s_tready_o are held.
module geodetic_to_ecef_convert #(
  parameter int unsigned ROTATION_STEPS = g2e_pkg::ROTATION_STEPS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  input  logic [95:0]  s_tdata_i,  // latitude_e7[30:0], longitude_e7[62:31], height_mm[89:63]
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  output logic [103:0] m_tdata_o   // x_mm[33:0], y_mm[67:34], z_mm[101:68]
);

  localparam int unsigned DIV_LAT    = 2;
  localparam int unsigned PIPE_DEPTH = DIV_LAT + ROTATION_STEPS + 27;
  localparam int unsigned HN         = g2e_pkg::HORNER_N;

  logic                  en;
  logic [PIPE_DEPTH-1:0] vld_q;

  assign en         = !m_tvalid_o || m_tready_i;
  assign s_tready_o = en;
  assign m_tvalid_o = vld_q[PIPE_DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], s_tvalid_i};
    end
  end

  // input stage: magnitudes and integer part of the radian conversion
  logic [31:0] ang_ext [2];
  logic [31:0] ang_mag [2];
  logic [62:0] mq_q    [2];
  logic        neg_q   [2];
  logic [26:0] h_q;

  assign ang_ext[0] = 32'(signed'(s_tdata_i[30:0]));
  assign ang_ext[1] = s_tdata_i[62:31];

  // per-angle path: conversion, fold, CORDIC cells, sine/cosine
  logic [63:0] cmag_q [2];
  logic [63:0] smag_q [2];
  logic        cneg_q [2];
  logic        sneg_q [2];

  for (genvar g = 0; g < 2; g++) begin : g_ang
    logic [63:0]                  side_d;
    logic [g2e_pkg::DIV_BITS-1:0] quo;
    logic signed [63:0]           rad;
    logic [63:0]                  rad_mag;
    logic signed [63:0]           z0_q;
    logic                         flip_q, flip_d;
    g2e_pkg::rot_t                rot_st [ROTATION_STEPS+1];

    assign ang_mag[g] = ang_ext[g][31] ? 32'd0 - ang_ext[g] : ang_ext[g];

    always_ff @(posedge clk_i) begin
      if (en) begin
        mq_q[g]  <= 63'(ang_mag[g]) * 63'(g2e_pkg::DEG_Q);
        neg_q[g] <= ang_ext[g][31];
      end
    end

    g2e_div_cell u_div (
      .clk_i(clk_i), .en_i(en), .m_i(ang_mag[g]), .quo_o(quo)
    );

    g2e_delay #(.W(64), .D(DIV_LAT - 1)) u_side (
      .clk_i(clk_i), .en_i(en), .d_i({neg_q[g], mq_q[g]}), .q_o(side_d)
    );

    assign rad_mag = 64'(side_d[62:0]) + 64'(quo);
    assign rad     = side_d[63] ? -signed'(rad_mag) : signed'(rad_mag);

    // fold into [-pi/2, pi/2]; the rotation result is negated afterwards
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (rad > signed'(g2e_pkg::HALF_PI_Q60)) begin
          z0_q   <= rad - signed'(g2e_pkg::PI_Q60);
          flip_q <= 1'b1;
        end else if (rad < -signed'(g2e_pkg::HALF_PI_Q60)) begin
          z0_q   <= rad + signed'(g2e_pkg::PI_Q60);
          flip_q <= 1'b1;
        end else begin
          z0_q   <= rad;
          flip_q <= 1'b0;
        end
      end
    end

    assign rot_st[0].x = signed'(g2e_pkg::GAIN_Q60);
    assign rot_st[0].y = '0;
    assign rot_st[0].z = z0_q;

    for (genvar j = 0; j < ROTATION_STEPS; j++) begin : g_rot
      g2e_cordic_cell #(.STEP(j)) u_cell (
        .clk_i(clk_i), .en_i(en), .st_i(rot_st[j]), .st_o(rot_st[j+1])
      );
    end

    g2e_delay #(.W(1), .D(ROTATION_STEPS)) u_flip (
      .clk_i(clk_i), .en_i(en), .d_i(flip_q), .q_o(flip_d)
    );

    // a zero with its sign flag set still multiplies to zero
    always_ff @(posedge clk_i) begin
      if (en) begin
        cneg_q[g] <= rot_st[ROTATION_STEPS].x[63] ^ flip_d;
        sneg_q[g] <= rot_st[ROTATION_STEPS].y[63] ^ flip_d;
        cmag_q[g] <= rot_st[ROTATION_STEPS].x[63] ?
                     unsigned'(-rot_st[ROTATION_STEPS].x) : unsigned'(rot_st[ROTATION_STEPS].x);
        smag_q[g] <= rot_st[ROTATION_STEPS].y[63] ?
                     unsigned'(-rot_st[ROTATION_STEPS].y) : unsigned'(rot_st[ROTATION_STEPS].y);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_q <= s_tdata_i[89:63];
    end
  end

  // prime-vertical radius: t = e2 sin^2 B, then the series
  logic [63:0] s2, t_w, n_w;
  logic [63:0] t_h  [HN];
  logic [63:0] g_h  [HN+1];
  logic [63:0] pr_h [HN];

  g2e_mul u_m_s2 (.clk_i(clk_i), .en_i(en), .a_i(smag_q[0]), .b_i(smag_q[0]), .p_o(s2));
  g2e_mul u_m_t  (.clk_i(clk_i), .en_i(en), .a_i(g2e_pkg::E2_Q60), .b_i(s2), .p_o(t_w));

  assign t_h[0] = t_w;
  assign g_h[0] = g2e_pkg::HORNER_G0;

  for (genvar j = 0; j < HN; j++) begin : g_horner
    g2e_mul u_m (.clk_i(clk_i), .en_i(en), .a_i(t_h[j]), .b_i(g_h[j]), .p_o(pr_h[j]));
    assign g_h[j+1] = g2e_pkg::HORNER_C[j] + pr_h[j];
    if (j < HN - 1) begin : g_tdly
      g2e_delay #(.W(64), .D(2)) u_t (
        .clk_i(clk_i), .en_i(en), .d_i(t_h[j]), .q_o(t_h[j+1])
      );
    end
  end

  g2e_mul u_m_n (.clk_i(clk_i), .en_i(en), .a_i(g2e_pkg::A_Q20), .b_i(g_h[HN]), .p_o(n_w));

  // side data aligned to the back end
  logic [26:0] h18, h21;
  logic [64:0] cb19;
  logic [64:0] sb21, cl21, sl21;

  g2e_delay #(.W(27), .D(DIV_LAT + ROTATION_STEPS + 19)) u_h18 (
    .clk_i(clk_i), .en_i(en), .d_i(h_q), .q_o(h18)
  );
  g2e_delay #(.W(27), .D(3)) u_h21 (.clk_i(clk_i), .en_i(en), .d_i(h18), .q_o(h21));
  g2e_delay #(.W(65), .D(19)) u_cb (
    .clk_i(clk_i), .en_i(en), .d_i({cneg_q[0], cmag_q[0]}), .q_o(cb19)
  );
  g2e_delay #(.W(65), .D(21)) u_sb (
    .clk_i(clk_i), .en_i(en), .d_i({sneg_q[0], smag_q[0]}), .q_o(sb21)
  );
  g2e_delay #(.W(65), .D(21)) u_cl (
    .clk_i(clk_i), .en_i(en), .d_i({cneg_q[1], cmag_q[1]}), .q_o(cl21)
  );
  g2e_delay #(.W(65), .D(21)) u_sl (
    .clk_i(clk_i), .en_i(en), .d_i({sneg_q[1], smag_q[1]}), .q_o(sl21)
  );

  // p = N + h, then (N + h) cos B and N e2
  logic signed [63:0] p_w;
  logic [63:0]        p_mag_q, n_r_q, qm_w, ne_w, n21;
  logic               p_neg_q, q_neg21;

  assign p_w = signed'(n_w) + (64'(signed'(h18)) <<< 20);

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_neg_q <= p_w[63];
      p_mag_q <= p_w[63] ? unsigned'(-p_w) : unsigned'(p_w);
      n_r_q   <= n_w;
    end
  end

  g2e_mul u_m_q  (.clk_i(clk_i), .en_i(en), .a_i(p_mag_q), .b_i(cb19[63:0]), .p_o(qm_w));
  g2e_mul u_m_ne (.clk_i(clk_i), .en_i(en), .a_i(n_r_q), .b_i(g2e_pkg::E2_Q60), .p_o(ne_w));

  g2e_delay #(.W(64), .D(2)) u_n21 (.clk_i(clk_i), .en_i(en), .d_i(n_r_q), .q_o(n21));
  g2e_delay #(.W(1), .D(2)) u_qn (
    .clk_i(clk_i), .en_i(en), .d_i(p_neg_q ^ cb19[64]), .q_o(q_neg21)
  );

  logic signed [63:0] zr_w;
  logic [63:0]        q_mag_q, zr_mag_q, clm_q, slm_q, sbm_q;
  logic [2:0]         sgn_q, sgn24;

  assign zr_w = signed'(n21) - signed'(ne_w) + (64'(signed'(h21)) <<< 20);

  always_ff @(posedge clk_i) begin
    if (en) begin
      q_mag_q  <= qm_w;
      zr_mag_q <= zr_w[63] ? unsigned'(-zr_w) : unsigned'(zr_w);
      clm_q    <= cl21[63:0];
      slm_q    <= sl21[63:0];
      sbm_q    <= sb21[63:0];
      sgn_q    <= {zr_w[63] ^ sb21[64], q_neg21 ^ sl21[64], q_neg21 ^ cl21[64]};
    end
  end

  logic [63:0] prod [3];

  g2e_mul u_m_x (.clk_i(clk_i), .en_i(en), .a_i(q_mag_q), .b_i(clm_q), .p_o(prod[0]));
  g2e_mul u_m_y (.clk_i(clk_i), .en_i(en), .a_i(q_mag_q), .b_i(slm_q), .p_o(prod[1]));
  g2e_mul u_m_z (.clk_i(clk_i), .en_i(en), .a_i(zr_mag_q), .b_i(sbm_q), .p_o(prod[2]));

  g2e_delay #(.W(3), .D(2)) u_sgn (.clk_i(clk_i), .en_i(en), .d_i(sgn_q), .q_o(sgn24));

  // round half up from Q20 millimetres
  logic [33:0] res_w [3];
  logic [103:0] tdata_q;

  for (genvar k = 0; k < 3; k++) begin : g_round
    logic signed [63:0] v, r;
    assign v = sgn24[k] ? -signed'(prod[k]) : signed'(prod[k]);
    assign r = (v + 64'sd524288) >>> 20;
    assign res_w[k] = r[33:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tdata_q <= {2'b00, res_w[2], res_w[1], res_w[0]};
    end
  end

  assign m_tdata_o = tdata_q;

  // a held output freezes every stage's valid bit
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline advanced while output was held");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> vld_q[0])
    else $error("accepted request did not enter the pipeline");

  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_o) |-> $past(vld_q[PIPE_DEPTH-2]))
    else $error("output valid without a request in the last stage");

endmodule
